/* hw/rtl/pidclp_pkg.sv */
package pidclp_pkg;

   // Field and register widths.
   localparam int unsigned GainWidth   = 16;
   localparam int unsigned InWidth     = 16;
   localparam int unsigned ErrWidth    = 17;
   localparam int unsigned DerWidth    = 18;
   localparam int unsigned IlimWidth   = 16;
   localparam int unsigned OlimWidth   = 15;
   localparam int unsigned CoeffWidth  = 9;
   localparam int unsigned OutWidth    = 16;
   localparam int unsigned FiltWidth   = 24;
   localparam int unsigned SumWidth    = 36;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CntWidth    = 5;

   // Last multiplier bit for signed PID terms and for unsigned filter weights.
   localparam logic [CntWidth-1:0] LastSignedBit   = 5'd17;
   localparam logic [CntWidth-1:0] LastUnsignedBit = 5'd8;

   // Filter weight of one (no filtering).
   localparam logic [CoeffWidth-1:0] CoeffOne = 9'd256;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4,
      CSR_FILTER_COEFF   = 3'd5
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [GainWidth-1:0]  PropGainReset  = 16'hF900;  // -7.0
   localparam logic [GainWidth-1:0]  IntegGainReset = 16'hF09A;  // -15.4
   localparam logic [GainWidth-1:0]  DerivGainReset = 16'h0000;
   localparam logic [IlimWidth-1:0]  IlimReset      = 16'd100;
   localparam logic [OlimWidth-1:0]  OlimReset      = 15'd8000;
   localparam logic [CoeffWidth-1:0] CoeffReset     = 9'd154;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PREP   = 5'b00010,
      ST_MUL    = 5'b00100,
      ST_CLAMP  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   // Product terms run through the shared serial multiplier.
   typedef enum logic [2:0] {
      TERM_PROP  = 3'd0,
      TERM_INTEG = 3'd1,
      TERM_DERIV = 3'd2,
      TERM_NEW   = 3'd3,
      TERM_OLD   = 3'd4
   } term_type;

endpackage

/* hw/rtl/pid_with_clamp_and_output_lowpass.sv */
// Positional PID rate controller with an anti-windup clamp on the integral and a
// first-order low-pass filter on the output. Each request beat carries a target and
// a measurement; the block returns one response beat with the filtered drive value,
// the clamped controller output and the error. All arithmetic is exact fixed point:
// gains are signed Q8.8, the filter weight is Q1.8 (values above 256 act as 256) and
// every right shift rounds toward minus infinity. The error is registered at the
// accepting edge; a prep step then updates the integral and derivative, three
// signed products of 18 bits each run on the multiplier, a clamp step scales and
// clamps the sum, two filter products of 9 bits each follow, and a finish step
// presents the response. The next request beat can be accepted while that
// response is presented. The single shift-and-add multiplier retires one
// multiplier bit per cycle and is shared by all five products. A finished response
// sits in the output register while the next request is accepted; the block holds
// off a new request while an item is in flight, and the finish step waits for as
// long as the previous response is still held in the output register. The user
// writes the configuration registers through the csr port only while the block is
// idle, and they take effect on the next item; the block itself does not enforce
// this.
module pid_with_clamp_and_output_lowpass (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pidclp_pkg::InWidth-1:0]   req_target,
   input  logic signed [pidclp_pkg::InWidth-1:0]   req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pidclp_pkg::OutWidth-1:0]  rsp_drive,
   output logic signed [pidclp_pkg::OutWidth-1:0]  rsp_pid_output,
   output logic signed [pidclp_pkg::ErrWidth-1:0]  rsp_error,
   input  logic                                csr_we,
   input  logic [pidclp_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [pidclp_pkg::GainWidth-1:0]        csr_wdata
);
   import pidclp_pkg::*;

   // Configuration registers.
   logic signed [GainWidth-1:0] prop_gain_ff;
   logic signed [GainWidth-1:0] integ_gain_ff;
   logic signed [GainWidth-1:0] deriv_gain_ff;
   logic [IlimWidth-1:0]        integral_limit_ff;
   logic [OlimWidth-1:0]        output_limit_ff;
   logic [CoeffWidth-1:0]       filter_coeff_ff;

   // Controller state carried from item to item.
   logic signed [ErrWidth-1:0]  accum_ff,   accum_in;
   logic signed [ErrWidth-1:0]  prev_ff,    prev_in;
   logic signed [FiltWidth-1:0] filt_ff,    filt_in;

   // Per-item working registers.
   state_type                   state_ff,   state_in;
   term_type                    term_ff,    term_in;
   logic signed [ErrWidth-1:0]  err_ff,     err_in;
   logic signed [ErrWidth-1:0]  acc_ff,     acc_in;
   logic signed [DerWidth-1:0]  der_ff,     der_in;
   logic signed [OutWidth-1:0]  u_ff,       u_in;
   logic signed [SumWidth-1:0]  sum_ff,     sum_in;
   logic signed [SumWidth-1:0]  mcand_ff,   mcand_in;
   logic [DerWidth-1:0]         mplier_ff,  mplier_in;
   logic [CntWidth-1:0]         cnt_ff,     cnt_in;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OutWidth-1:0]  drive_ff,     drive_in;
   logic signed [OutWidth-1:0]  pid_out_ff,   pid_out_in;
   logic signed [ErrWidth-1:0]  rsp_err_ff,   rsp_err_in;

   // Combinational helpers.
   logic                        req_take;
   logic                        rsp_free;
   logic signed [DerWidth-1:0]  acc_sum;
   logic signed [DerWidth-1:0]  ilim_pos;
   logic signed [DerWidth-1:0]  ilim_neg;
   logic signed [ErrWidth-1:0]  acc_clamped;
   logic signed [SumWidth-9:0]  sum_scaled;
   logic signed [SumWidth-9:0]  olim_pos;
   logic signed [SumWidth-9:0]  olim_neg;
   logic signed [OutWidth-1:0]  u_clamped;
   logic [CoeffWidth-1:0]       c_eff;
   logic [CoeffWidth-1:0]       d_eff;
   logic                        term_signed;
   logic                        last_bit;
   logic signed [SumWidth-1:0]  sum_step;
   logic signed [FiltWidth-1:0] filt_new;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Only an idle sequencer takes a new request beat.
   assign req_stall = (state_ff != ST_IDLE);

   // Integral update with symmetric clamp.
   assign acc_sum  = {accum_ff[ErrWidth-1], accum_ff} + {err_ff[ErrWidth-1], err_ff};
   assign ilim_pos = {2'b00, integral_limit_ff};
   assign ilim_neg = -ilim_pos;
   always_comb begin
      if (acc_sum > ilim_pos) begin
         acc_clamped = ilim_pos[ErrWidth-1:0];
      end else if (acc_sum < ilim_neg) begin
         acc_clamped = ilim_neg[ErrWidth-1:0];
      end else begin
         acc_clamped = acc_sum[ErrWidth-1:0];
      end
   end

   // Scale the PID sum back by eight bits (floor) and clamp it to the output limit.
   assign sum_scaled = sum_ff[SumWidth-1:8];
   assign olim_pos   = {13'd0, output_limit_ff};
   assign olim_neg   = -olim_pos;
   always_comb begin
      if (sum_scaled > olim_pos) begin
         u_clamped = olim_pos[OutWidth-1:0];
      end else if (sum_scaled < olim_neg) begin
         u_clamped = olim_neg[OutWidth-1:0];
      end else begin
         u_clamped = sum_scaled[OutWidth-1:0];
      end
   end

   // Filter weights; a weight above one acts as one.
   assign c_eff = (filter_coeff_ff > CoeffOne) ? CoeffOne : filter_coeff_ff;
   assign d_eff = CoeffOne - c_eff;

   // Serial multiplier step. PID terms have a signed 18-bit multiplier whose top
   // bit carries negative weight; the filter weights are unsigned 9-bit values.
   assign term_signed = (term_ff == TERM_PROP) || (term_ff == TERM_INTEG) ||
                        (term_ff == TERM_DERIV);
   assign last_bit    = term_signed ? (cnt_ff == LastSignedBit) :
                                      (cnt_ff == LastUnsignedBit);
   always_comb begin
      if (!mplier_ff[0]) begin
         sum_step = sum_ff;
      end else if (term_signed && last_bit) begin
         sum_step = sum_ff - mcand_ff;
      end else begin
         sum_step = sum_ff + mcand_ff;
      end
   end

   // The filter sum is c*u*256 + (256-c)*y_prev; its floor by 256 is the new state.
   assign filt_new = sum_ff[FiltWidth+7:8];

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      der_in       = der_ff;
      u_in         = u_ff;
      sum_in       = sum_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      accum_in     = accum_ff;
      prev_in      = prev_ff;
      filt_in      = filt_ff;
      rsp_valid_in = rsp_valid_ff;
      drive_in     = drive_ff;
      pid_out_in   = pid_out_ff;
      rsp_err_in   = rsp_err_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               err_in   = {req_target[InWidth-1], req_target} -
                          {req_measurement[InWidth-1], req_measurement};
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            acc_in    = acc_clamped;
            der_in    = {err_ff[ErrWidth-1], err_ff} - {prev_ff[ErrWidth-1], prev_ff};
            accum_in  = acc_clamped;
            prev_in   = err_ff;
            sum_in    = '0;
            term_in   = TERM_PROP;
            mcand_in  = {{(SumWidth-GainWidth){prop_gain_ff[GainWidth-1]}}, prop_gain_ff};
            mplier_in = {err_ff[ErrWidth-1], err_ff};
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            sum_in    = sum_step;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 5'd1;
            if (last_bit) begin
               cnt_in = '0;
               unique case (term_ff)
                  TERM_PROP: begin
                     term_in   = TERM_INTEG;
                     mcand_in  = {{(SumWidth-GainWidth){integ_gain_ff[GainWidth-1]}},
                                  integ_gain_ff};
                     mplier_in = {acc_ff[ErrWidth-1], acc_ff};
                  end
                  TERM_INTEG: begin
                     term_in   = TERM_DERIV;
                     mcand_in  = {{(SumWidth-GainWidth){deriv_gain_ff[GainWidth-1]}},
                                  deriv_gain_ff};
                     mplier_in = der_ff;
                  end
                  TERM_DERIV: begin
                     state_in = ST_CLAMP;
                  end
                  TERM_NEW: begin
                     term_in   = TERM_OLD;
                     mcand_in  = {{(SumWidth-FiltWidth){filt_ff[FiltWidth-1]}}, filt_ff};
                     mplier_in = {9'd0, d_eff};
                  end
                  TERM_OLD: begin
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLAMP: begin
            // Start the filter with the new output weighted by c, in Q.8.
            u_in      = u_clamped;
            sum_in    = '0;
            term_in   = TERM_NEW;
            mcand_in  = {{(SumWidth-OutWidth-8){u_clamped[OutWidth-1]}}, u_clamped, 8'd0};
            mplier_in = {9'd0, c_eff};
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_FINISH: begin
            // Wait here until the response register is free.
            if (rsp_free) begin
               filt_in      = filt_new;
               drive_in     = filt_new[FiltWidth-1:8];
               pid_out_in   = u_ff;
               rsp_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_PROP;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         accum_ff     <= '0;
         prev_ff      <= '0;
         filt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         accum_ff     <= accum_in;
         prev_ff      <= prev_in;
         filt_ff      <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      acc_ff     <= acc_in;
      der_ff     <= der_in;
      u_ff       <= u_in;
      sum_ff     <= sum_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      drive_ff   <= drive_in;
      pid_out_ff <= pid_out_in;
      rsp_err_ff <= rsp_err_in;
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= PropGainReset;
         integ_gain_ff     <= IntegGainReset;
         deriv_gain_ff     <= DerivGainReset;
         integral_limit_ff <= IlimReset;
         output_limit_ff   <= OlimReset;
         filter_coeff_ff   <= CoeffReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:      prop_gain_ff      <= csr_wdata;
            CSR_INTEG_GAIN:     integ_gain_ff     <= csr_wdata;
            CSR_DERIV_GAIN:     deriv_gain_ff     <= csr_wdata;
            CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_wdata;
            CSR_OUTPUT_LIMIT:   output_limit_ff   <= csr_wdata[OlimWidth-1:0];
            CSR_FILTER_COEFF:   filter_coeff_ff   <= csr_wdata[CoeffWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive      = drive_ff;
   assign rsp_pid_output = pid_out_ff;
   assign rsp_error      = rsp_err_ff;

   // An accepted request always moves on to the integral update.
   a_take_to_prep: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_PREP))
      else $error("accepted request did not start the integral update");

   // A new response beat appears only out of the finish step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the finish step");

   // Leaving the finish step always presents a response.
   a_finish_presents: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finish step did not present a response");

   // The bit counter never runs past the last multiplier bit.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff <= LastSignedBit))
      else $error("multiplier bit counter out of range");

endmodule

/* verif/pid_with_clamp_and_output_lowpass_tb.sv */
`timescale 1ns / 1ps

module pid_with_clamp_and_output_lowpass_tb;
   import pidclp_pkg::*;

   // Run shape. Each side adds a random idle gap before each beat, bounded by MaxIdle.
   // Two long receiver hold-offs also fit well inside the cycle limit.
   localparam int unsigned ResetCycles   = 6;
   localparam int unsigned MaxIdle       = 18;
   localparam int unsigned LongHold      = 400;
   localparam int unsigned RandomPhases  = 6;
   localparam int unsigned ItemsPerPhase = 72;
   localparam int unsigned SettleCycles  = 100;
   localparam int unsigned CycleLimit    = 400000;
   localparam int unsigned ReportLimit   = 10;

   // Register indexes with no register behind them; writes to them must be ignored.
   localparam logic [CsrIdxWidth-1:0] CsrSpareLow  = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CsrSpareHigh = 3'd7;

   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic signed [InWidth-1:0]   req_target      = '0;
   logic signed [InWidth-1:0]   req_measurement = '0;
   logic                        rsp_valid;
   logic                        rsp_stall       = 1'b1;
   logic signed [OutWidth-1:0]  rsp_drive;
   logic signed [OutWidth-1:0]  rsp_pid_output;
   logic signed [ErrWidth-1:0]  rsp_error;
   logic                        csr_we          = 1'b0;
   logic [CsrIdxWidth-1:0]      csr_index       = '0;
   logic [GainWidth-1:0]        csr_wdata       = '0;

   pid_with_clamp_and_output_lowpass dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_target      (req_target),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_pid_output  (rsp_pid_output),
      .rsp_error       (rsp_error),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // One response beat, field by field.
   typedef struct packed {
      logic signed [OutWidth-1:0] drive;
      logic signed [OutWidth-1:0] pid_output;
      logic signed [ErrWidth-1:0] error;
   } rate_beat_type;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   // One row of the directed table: either a register write or a request beat. A
   // request row whose typed flag is set carries its response, which was worked out
   // by hand. Every other request row is checked against the controller model below.
   typedef struct packed {
      row_kind_type               kind;
      logic [CsrIdxWidth-1:0]     reg_index;
      logic [GainWidth-1:0]       reg_value;
      logic signed [InWidth-1:0]  target;
      logic signed [InWidth-1:0]  measurement;
      logic                       typed;
      rate_beat_type              beat;
   } plan_row_type;

   // The testbench keeps its own copy of the register file. The copy follows every
   // write, so the model sees the same gains, limits and filter weight as the block.
   int gain_p, gain_i, gain_d, integ_limit, out_limit, lp_coeff;

   // This is the controller state held by the model: the clamped integral, the
   // error from the last item, and the Q16.8 low-pass value.
   logic signed [ErrWidth-1:0]  integ_sum;
   logic signed [ErrWidth-1:0]  model_prev_err;
   logic signed [FiltWidth-1:0] lowpass_state;

   // These responses are still owed by the block, oldest first.
   rate_beat_type expected_beats[$];

   // This flag and these limits coordinate the two sides. Both sides can also drop
   // their idle cycles.
   logic        hold_order = 1'b0;
   int unsigned send_idle_max = MaxIdle;
   int unsigned recv_idle_max = MaxIdle;

   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;
   int unsigned beats_seen  = 0;
   int unsigned bad_beats   = 0;
   int unsigned reg_writes  = 0;
   int unsigned long_holds  = 0;
   int unsigned sender_pauses = 0;

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // This function advances the controller model by one accepted item and returns
   // the response the block owes for it. An arithmetic shift right of a signed
   // longint is a floor, which is the rounding the block uses throughout.
   function automatic rate_beat_type step_controller(logic signed [InWidth-1:0] target,
                                                     logic signed [InWidth-1:0] measurement);
      longint err, acc, der, sum, u, c, y, drv;
      rate_beat_type beat;
      err = longint'(target) - longint'(measurement);
      acc = clamp_sym(longint'(integ_sum) + err, integ_limit);
      der = err - longint'(model_prev_err);
      sum = gain_p * err + gain_i * acc + gain_d * der;
      u   = clamp_sym(sum >>> 8, out_limit);
      // A weight above one acts as one, so the filter never overshoots its input.
      c   = (lp_coeff > 256) ? 256 : lp_coeff;
      y   = (c * u * 256 + (256 - c) * longint'(lowpass_state)) >>> 8;
      drv = y >>> 8;
      integ_sum      = acc[ErrWidth-1:0];
      model_prev_err = err[ErrWidth-1:0];
      lowpass_state  = y[FiltWidth-1:0];
      beat.drive      = drv[OutWidth-1:0];
      beat.pid_output = u[OutWidth-1:0];
      beat.error      = err[ErrWidth-1:0];
      return beat;
   endfunction

   function automatic plan_row_type item_row(logic signed [InWidth-1:0] target,
                                             logic signed [InWidth-1:0] measurement);
      plan_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.target = target;
      row.measurement = measurement;
      return row;
   endfunction

   function automatic plan_row_type checked_row(logic signed [InWidth-1:0] target,
                                                logic signed [InWidth-1:0] measurement,
                                                rate_beat_type beat);
      plan_row_type row;
      row = item_row(target, measurement);
      row.typed = 1'b1;
      row.beat = beat;
      return row;
   endfunction

   function automatic plan_row_type reg_row(logic [CsrIdxWidth-1:0] index,
                                            logic [GainWidth-1:0] value);
      plan_row_type row;
      row = '0;
      row.kind = ROW_REG;
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   // This task writes one register at the next edge and then updates the model's
   // copy of it. Bits beyond a register's width are dropped, as the block does. The
   // caller lowers the write enable after its last write, so back-to-back writes keep
   // it high.
   task automatic write_reg(logic [CsrIdxWidth-1:0] index, logic [GainWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      reg_writes++;
      unique case (index)
         CSR_PROP_GAIN:      gain_p = int'($signed(value));
         CSR_INTEG_GAIN:     gain_i = int'($signed(value));
         CSR_DERIV_GAIN:     gain_d = int'($signed(value));
         CSR_INTEGRAL_LIMIT: integ_limit = int'(value);
         CSR_OUTPUT_LIMIT:   out_limit = int'(value[OlimWidth-1:0]);
         CSR_FILTER_COEFF:   lp_coeff = int'(value[CoeffWidth-1:0]);
         default: ;
      endcase
   endtask

   // This task stops offering request beats and waits until every owed response
   // has arrived. The block is then idle, and its registers may be written.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // This task offers one request beat after a random gap and holds it steady until
   // the block takes it. At the accepting edge the model runs, and the expected
   // response is queued. Rows with a typed response queue that response instead,
   // but the model still runs so that its state stays in step with the block.
   task automatic send_item(logic signed [InWidth-1:0] target,
                            logic signed [InWidth-1:0] measurement,
                            logic typed, rate_beat_type typed_beat);
      int unsigned gap;
      rate_beat_type beat;
      gap = $urandom_range(0, send_idle_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_target      <= target;
      req_measurement <= measurement;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beat = step_controller(target, measurement);
      expected_beats.push_back(typed ? typed_beat : beat);
      items_sent++;
   endtask

   // The watchdog counts cycles. A stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycle_count, expected_beats.size());
         $display("status: fail");
         $finish;
      end
   end

   // This is the response side. Before each beat it draws a hold-off. When the
   // sender asks for it, it holds off for a long stretch instead. Every accepted beat
   // is compared with the oldest owed response.
   initial begin : response_side
      int unsigned hold;
      rate_beat_type want;
      wait (!reset);
      forever begin
         if (hold_order) begin
            hold = LongHold;
            hold_order = 1'b0;
            long_holds++;
         end else begin
            hold = $urandom_range(0, recv_idle_max);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         beats_seen++;
         if (expected_beats.size() == 0) begin
            bad_beats++;
            if (bad_beats <= ReportLimit)
               $display("unexpected response beat: drive %0d pid_output %0d error %0d",
                        rsp_drive, rsp_pid_output, rsp_error);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_drive !== want.drive || rsp_pid_output !== want.pid_output ||
                rsp_error !== want.error) begin
               bad_beats++;
               if (bad_beats <= ReportLimit)
                  $display({"response beat %0d: expected drive %0d pid_output %0d ",
                            "error %0d, got drive %0d pid_output %0d error %0d"},
                           beats_seen, want.drive, want.pid_output, want.error,
                           rsp_drive, rsp_pid_output, rsp_error);
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type plan[$];
      logic        in_regs;
      int unsigned phase, n, pick;
      int          goal, meas, nudge;
      logic [GainWidth-1:0] kp, ki, kd, il, ol, co;
      logic [InWidth-1:0]   corners[4];

      corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

      // The model starts with the register values and the cleared state that
      // follow reset.
      gain_p = -1792;
      gain_i = -3942;
      gain_d = 0;
      integ_limit = 100;
      out_limit = 8000;
      lp_coeff = 154;
      integ_sum = '0;
      model_prev_err = '0;
      lowpass_state = '0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed part runs first. The first three items are checked against
      // hand-worked responses under the reset settings. A zero error from cleared
      // state gives all zeros. The widest positive error saturates the integral at
      // +100 and the output at -8000, and the filter moves 154/256 of the way there.
      // The widest negative error then swings both clamps to the opposite side.
      plan.push_back(checked_row(16'sd0, 16'sd0, rate_beat_type'{16'sd0, 16'sd0, 17'sd0}));
      plan.push_back(checked_row(16'sh7FFF, 16'sh8000,
                                 rate_beat_type'{-16'sd4813, -16'sd8000, 17'sd65535}));
      plan.push_back(checked_row(16'sh8000, 16'sh7FFF,
                                 rate_beat_type'{16'sd2895, 16'sd8000, -17'sd65535}));
      plan.push_back(item_row(16'sh8000, 16'sh8000));
      plan.push_back(item_row(16'sh7FFF, 16'sh7FFF));
      plan.push_back(item_row(16'sd5, -16'sd3));
      plan.push_back(item_row(-16'sd1, 16'sd0));
      // Next come the gain extremes, with the derivative term switched on.
      plan.push_back(reg_row(CSR_DERIV_GAIN, 16'h7FFF));
      plan.push_back(reg_row(CSR_PROP_GAIN, 16'h8000));
      plan.push_back(reg_row(CSR_INTEG_GAIN, 16'h7FFF));
      plan.push_back(item_row(16'sd100, -16'sd200));
      plan.push_back(item_row(-16'sd300, 16'sd50));
      plan.push_back(item_row(16'sh5555, 16'shAAAA));
      // A zero limit forces both the integral and the output to zero.
      plan.push_back(reg_row(CSR_INTEGRAL_LIMIT, 16'h0000));
      plan.push_back(reg_row(CSR_OUTPUT_LIMIT, 16'h0000));
      plan.push_back(item_row(16'sd1000, 16'sd0));
      plan.push_back(item_row(-16'sd1000, 16'sd0));
      // Now the limits go wide open. The top bit of the output limit is beyond the
      // register's width and must be dropped. The filter weight goes above one.
      plan.push_back(reg_row(CSR_OUTPUT_LIMIT, 16'hFFFF));
      plan.push_back(reg_row(CSR_INTEGRAL_LIMIT, 16'hFFFF));
      plan.push_back(reg_row(CSR_FILTER_COEFF, 16'd300));
      plan.push_back(item_row(16'sd200, 16'sd0));
      plan.push_back(item_row(-16'sd200, 16'sd7));
      plan.push_back(reg_row(CSR_FILTER_COEFF, 16'd511));
      plan.push_back(item_row(16'sh7FFF, 16'sh8000));
      // With a zero weight the filter holds its value.
      plan.push_back(reg_row(CSR_FILTER_COEFF, 16'd0));
      plan.push_back(item_row(16'sd1234, -16'sd4321));
      plan.push_back(item_row(16'sh8000, 16'sh7FFF));
      // Writes to the spare indexes must leave every register as it was.
      plan.push_back(reg_row(CSR_FILTER_COEFF, 16'd256));
      plan.push_back(reg_row(CsrSpareLow, 16'h1234));
      plan.push_back(reg_row(CsrSpareHigh, 16'hFFFF));
      plan.push_back(item_row(16'sd77, -16'sd77));
      plan.push_back(item_row(16'shAAAA, 16'sh5555));

      in_regs = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            if (!in_regs) drain_results();
            in_regs = 1'b1;
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            if (in_regs) csr_we <= 1'b0;
            in_regs = 1'b0;
            send_item(plan[i].target, plan[i].measurement, plan[i].typed, plan[i].beat);
         end
      end

      // The random part runs in phases. Each phase writes a fresh setting to every
      // register. Most items follow a simple plant: the measurement moves toward a
      // slowly changing target, so the integral spends time both inside and at its
      // clamp. The rest are fully random values or corner values.
      goal = 0;
      meas = 0;
      for (phase = 0; phase < RandomPhases; phase++) begin
         drain_results();
         unique case (phase)
            1: begin
               kp = 16'h7FFF; ki = 16'h7FFF; kd = 16'h7FFF;
               il = 16'hFFFF; ol = 16'h7FFF; co = 16'd511;
            end
            2: begin
               kp = 16'h8000; ki = 16'h8000; kd = 16'h8000;
               il = 16'h0000; ol = 16'h0001; co = 16'd1;
            end
            default: begin
               kp = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 4096) - 2048);
               ki = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 4096) - 2048);
               kd = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1024) - 512);
               il = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
               ol = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
               co = 16'($urandom_range(0, 511));
            end
         endcase
         write_reg(CSR_PROP_GAIN, kp);
         write_reg(CSR_INTEG_GAIN, ki);
         write_reg(CSR_DERIV_GAIN, kd);
         write_reg(CSR_INTEGRAL_LIMIT, il);
         write_reg(CSR_OUTPUT_LIMIT, ol);
         write_reg(CSR_FILTER_COEFF, co);
         csr_we <= 1'b0;

         // Some phases drop the idle cycles on one side or on both.
         send_idle_max = (phase == 3 || phase == 4) ? 0 : MaxIdle;
         recv_idle_max = (phase == 4 || phase == 5) ? 0 : MaxIdle;

         for (n = 0; n < ItemsPerPhase; n++) begin
            // A long receiver hold-off lets the block back up. The sender keeps
            // offering beats while it waits.
            if (n == 30 && (phase == 0 || phase == 5)) hold_order = 1'b1;
            // At one point the sender pauses until all owed responses have arrived.
            if (n == 40 && phase == 1) begin
               drain_results();
               sender_pauses++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               if ($urandom_range(0, 15) == 0) goal = int'($urandom_range(0, 8000)) - 4000;
               nudge = int'($urandom_range(0, 400)) - 200;
               meas = meas + nudge + (goal - meas) / 8;
               if (meas > 32767) meas = 32767;
               if (meas < -32768) meas = -32768;
               send_item(goal[InWidth-1:0], meas[InWidth-1:0], 1'b0, '0);
            end else if (pick < 8) begin
               send_item(16'($urandom), 16'($urandom), 1'b0, '0);
            end else begin
               send_item(corners[$urandom_range(0, 3)], corners[$urandom_range(0, 3)],
                         1'b0, '0);
            end
         end
      end

      // All stimulus is in. The testbench collects the remaining responses and then
      // watches a little longer for stray beats.
      drain_results();
      repeat (SettleCycles) @(posedge clock);

      $display("%0d request beats and %0d response beats over %0d register writes",
               items_sent, beats_seen, reg_writes);
      $display("%0d long response hold-offs, %0d sender pauses, %0d bad response beats",
               long_holds, sender_pauses, bad_beats);
      if (bad_beats == 0 && expected_beats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
